@@ src/papu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// papu_pkg
// Shared types and constants for the alpha premultiply / unpremultiply core.
// ----------------------------------------------------------------------------
package papu_pkg;

	localparam int unsigned PIXEL_W    = 32;
	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned NUM_LANES  = PIXEL_W / CHAN_W;
	localparam int unsigned LANE_IDX_W = $clog2(NUM_LANES);
	localparam int unsigned RECIP_W    = 24;
	localparam int unsigned FRAC_BITS  = 16;
	localparam int unsigned RECIP_NUM  = 255 << FRAC_BITS;
	localparam int unsigned ROUND_HALF = 32768;
	localparam int unsigned CFG_DATA_W = 2;

	localparam logic [LANE_IDX_W-1:0] ALPHA_LANE_RESET = LANE_IDX_W'(3);

	typedef enum logic {
		DIR_PREMULTIPLY,
		DIR_UNPREMULTIPLY
	} dir_t;

	typedef enum logic {
		REG_CONVERT_DIRECTION,
		REG_ALPHA_BYTE_POSITION
	} reg_idx_t;

	typedef struct packed {
		dir_t                  dir;
		logic [LANE_IDX_W-1:0] alpha_lane;
	} cfg_t;

endpackage

`default_nettype wire

@@ src/papu_convert.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// papu_convert
// Converts the three color lanes of one pixel by its alpha; alpha passes.
// ----------------------------------------------------------------------------
module papu_convert (
	input  wire papu_pkg::cfg_t              cfg,
	input  wire logic [papu_pkg::PIXEL_W-1:0] pixel,
	output logic      [papu_pkg::PIXEL_W-1:0] result
);
	import papu_pkg::*;

	logic [CHAN_W-1:0]  chan [NUM_LANES];
	logic [RECIP_W-1:0] recip_tbl [256];
	logic [CHAN_W-1:0]  alpha;
	logic [RECIP_W-1:0] recip;

	assign recip_tbl[0] = '0;

	for (genvar i = 1; i < 256; i++) begin : g_recip
		localparam int unsigned RecipVal = (RECIP_NUM + i - 1) / i;
		assign recip_tbl[i] = RECIP_W'(RecipVal);
	end

	for (genvar k = 0; k < NUM_LANES; k++) begin : g_split
		assign chan[k] = pixel[k*CHAN_W +: CHAN_W];
	end

	assign alpha = chan[cfg.alpha_lane];
	assign recip = recip_tbl[alpha];

	for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
		logic [2*CHAN_W-1:0]        prod_ca;
		logic [RECIP_W-1:0]         prem_sum;
		logic [CHAN_W+RECIP_W-1:0]  unprem_prod;
		logic [CHAN_W-1:0]          conv;

		assign prod_ca     = chan[k] * alpha;
		assign prem_sum    = {prod_ca, {CHAN_W{1'b0}}} + RECIP_W'(prod_ca)
			+ RECIP_W'(ROUND_HALF);
		assign unprem_prod = chan[k] * recip;

		always_comb begin
			if (cfg.alpha_lane == LANE_IDX_W'(k)) begin
				conv = alpha;
			end else if (cfg.dir == DIR_UNPREMULTIPLY) begin
				conv = unprem_prod[FRAC_BITS +: CHAN_W];
			end else begin
				conv = prem_sum[FRAC_BITS +: CHAN_W];
			end
		end

		assign result[k*CHAN_W +: CHAN_W] = conv;
	end

endmodule

`default_nettype wire

@@ src/pixel_alpha_premultiply_unpremultiply_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_alpha_premultiply_unpremultiply_core
// Streams 32-bit pixels and premultiplies or unpremultiplies color by alpha.
// Pipeline: accepted pixel goes to input reg, then is converted into result reg.
// Throughput: one pixel per cycle unless the output stalls; one lane multiplier pass.
// Reset: clears both pipeline valids; direction to premultiply, alpha lane 3.
// ----------------------------------------------------------------------------
module pixel_alpha_premultiply_unpremultiply_core (
	input  wire  logic                           clk,
	input  wire  logic                           arst_n,
	input  wire  logic                           s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire  logic [papu_pkg::PIXEL_W-1:0]    s_axis_tdata,  // [31:0] pixel_in
	output logic                                 m_axis_tvalid,
	input  wire  logic                           m_axis_tready,
	output logic       [papu_pkg::PIXEL_W-1:0]    m_axis_tdata,  // [31:0] pixel_out
	input  wire  logic                           cfg_we,
	input  wire  papu_pkg::reg_idx_t             cfg_index,
	input  wire  logic [papu_pkg::CFG_DATA_W-1:0] cfg_data
);
	import papu_pkg::*;

	cfg_t               cfg_q;
	logic               valid_s1;
	logic [PIXEL_W-1:0] pixel_s1;
	logic               valid_s2;
	logic [PIXEL_W-1:0] pixel_s2;
	logic [PIXEL_W-1:0] conv_pixel;
	logic               adv_s2;
	logic               adv_s1;

	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = pixel_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dir        <= DIR_PREMULTIPLY;
			cfg_q.alpha_lane <= ALPHA_LANE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CONVERT_DIRECTION:   cfg_q.dir <= dir_t'(cfg_data[0]);
				REG_ALPHA_BYTE_POSITION: cfg_q.alpha_lane <= cfg_data[LANE_IDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			pixel_s1 <= s_axis_tdata;
		end
		if (adv_s2 && valid_s1) begin
			pixel_s2 <= conv_pixel;
		end
	end

	papu_convert u_convert (
		.cfg    (cfg_q),
		.pixel  (pixel_s1),
		.result (conv_pixel)
	);

`ifndef NO_ASSERTIONS
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && valid_s2 && !m_axis_tready))
		else $error("input stalled while pipeline has room");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> m_axis_tvalid)
		else $error("converted pixel lost between stages");

	a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> (valid_s1 && $stable(pixel_s1)))
		else $error("stalled input stage changed");
`endif

endmodule

`default_nettype wire
